// ===== hdl/smx_pkg.sv =====
package smx_pkg;

   localparam int DATA_W      = 32;
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_OUT_W = 9;
   localparam int STATUS_W    = 3;
   localparam int KIND_W      = 2;
   localparam int PRIM_W      = DATA_W - KIND_W;
   localparam int STEP_W      = $clog2(DATA_W);

   // Instruction types held in the top two bits.
   localparam logic [KIND_W-1:0] KIND_PUSH_LO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRIM_LO = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PUSH_HI = 2'd2;
   localparam logic [KIND_W-1:0] KIND_PRIM_HI = 2'd3;

   // Primitive numbers.
   localparam logic [PRIM_W-1:0] PRIM_HALT = 30'd0;
   localparam logic [PRIM_W-1:0] PRIM_ADD  = 30'd1;
   localparam logic [PRIM_W-1:0] PRIM_SUB  = 30'd2;
   localparam logic [PRIM_W-1:0] PRIM_MUL  = 30'd3;
   localparam logic [PRIM_W-1:0] PRIM_DIV  = 30'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HALT      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd6;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

// ===== hdl/smx_ram.sv =====
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/smx_alu.sv =====
module smx_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  smx_pkg::alu_ctl_type       ctl,
   input  logic [smx_pkg::DATA_W-1:0] opnd_a,
   input  logic [smx_pkg::DATA_W-1:0] opnd_b,
   output logic                       done,
   output logic [smx_pkg::DATA_W-1:0] result
);
   import smx_pkg::*;

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_FIN
   } alu_state_type;

   alu_state_type     state_ff;
   alu_op_type        op_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] opa_ff;
   logic [DATA_W-1:0] opb_ff;
   logic              neg_ff;
   logic [STEP_W-1:0] step_ff;

   logic [DATA_W:0]   add_x;
   logic [DATA_W:0]   add_y;
   logic              add_sub;
   logic [DATA_W:0]   add_sum;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;

   // The one adder is shared by add, subtract, each multiply step and each
   // trial subtraction of the divider.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         A_IDLE: begin
            add_x   = {1'b0, opnd_a};
            add_y   = {1'b0, opnd_b};
            add_sub = (ctl.op == ALU_SUB);
         end
         A_RUN: begin
            if (op_ff == ALU_MUL) begin
               add_x = {1'b0, acc_ff};
               add_y = {1'b0, (opb_ff[0] ? opa_ff : '0)};
            end else begin
               add_x   = {acc_ff, opb_ff[DATA_W-1]};
               add_y   = {1'b0, opa_ff};
               add_sub = 1'b1;
            end
         end
         default: begin
            add_x = '0;
         end
      endcase
      add_sum = add_x + (add_y ^ {(DATA_W + 1){add_sub}}) + (DATA_W + 1)'(add_sub);
   end

   assign mag_a = opnd_a[DATA_W-1] ? (DATA_W'(0) - opnd_a) : opnd_a;
   assign mag_b = opnd_b[DATA_W-1] ? (DATA_W'(0) - opnd_b) : opnd_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         unique case (state_ff)
            A_IDLE: begin
               if (ctl.start) begin
                  op_ff   <= ctl.op;
                  step_ff <= '0;
                  neg_ff  <= 1'b0;
                  unique case (ctl.op)
                     ALU_ADD, ALU_SUB: begin
                        acc_ff   <= add_sum[DATA_W-1:0];
                        state_ff <= A_FIN;
                     end
                     ALU_MUL: begin
                        acc_ff   <= '0;
                        opa_ff   <= opnd_a;
                        opb_ff   <= opnd_b;
                        state_ff <= A_RUN;
                     end
                     default: begin
                        // Divide the magnitudes; the quotient sign is fixed at the end.
                        acc_ff   <= '0;
                        opa_ff   <= mag_b;
                        opb_ff   <= mag_a;
                        neg_ff   <= opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
                        state_ff <= A_RUN;
                     end
                  endcase
               end
            end
            A_RUN: begin
               if (op_ff == ALU_MUL) begin
                  acc_ff <= add_sum[DATA_W-1:0];
                  opa_ff <= {opa_ff[DATA_W-2:0], 1'b0};
                  opb_ff <= {1'b0, opb_ff[DATA_W-1:1]};
               end else begin
                  if (!add_sum[DATA_W]) begin
                     acc_ff <= add_sum[DATA_W-1:0];
                  end else begin
                     acc_ff <= add_x[DATA_W-1:0];
                  end
                  opb_ff <= {opb_ff[DATA_W-2:0], ~add_sum[DATA_W]};
               end
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DATA_W - 1)) begin
                  state_ff <= A_FIN;
               end
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done = (state_ff == A_FIN);

   always_comb begin
      if (op_ff == ALU_DIV) begin
         result = neg_ff ? (DATA_W'(0) - opb_ff) : opb_ff;
      end else begin
         result = acc_ff;
      end
   end

endmodule

// ===== hdl/stack_machine_executor.sv =====
// The registered result follows S_DONE for push, halt, ignored, underflow, overflow and unknown
// items; divide by zero passes S_OPER first; add and subtract pass S_OPER and S_ALU; multiply
// and divide wait in S_ALU for the 32 single-bit steps of the shared shift-and-add / restoring-divide unit.
// One item at a time: the next item is accepted the cycle after the result is registered.
// Synchronous reset empties the stack and restarts the machine; stack memory is not cleared.
module stack_machine_executor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [smx_pkg::DATA_W-1:0]             req_instruction,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [smx_pkg::DATA_W-1:0]      rsp_top_of_stack,
   output logic [smx_pkg::DEPTH_OUT_W-1:0]        rsp_stack_depth,
   output logic [smx_pkg::STATUS_W-1:0]           rsp_status
);
   import smx_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_OPER,
      S_ALU,
      S_DONE
   } state_type;

   state_type            state_ff,      state_in;
   logic [DATA_W-1:0]    tos_ff,        tos_in;
   logic [COUNT_W-1:0]   count_ff,      count_in;
   logic                 running_ff,    running_in;
   logic [STATUS_W-1:0]  status_ff,     status_in;
   alu_op_type           op_ff,         op_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0]    rsp_top_ff,    rsp_top_in;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic [KIND_W-1:0]    kind;
   logic [PRIM_W-1:0]    prim;
   logic [COUNT_W-1:0]   count_less1;
   logic [COUNT_W-1:0]   count_less2;
   logic                 ram_wr_en;
   logic [DATA_W-1:0]    ram_rd_data;
   alu_ctl_type          alu_ctl;
   logic                 alu_done;
   logic [DATA_W-1:0]    alu_result;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign kind        = req_instruction[DATA_W-1:PRIM_W];
   assign prim        = req_instruction[PRIM_W-1:0];
   assign count_less1 = count_ff - COUNT_W'(1);
   assign count_less2 = count_ff - COUNT_W'(2);

   // The top entry lives in tos_ff; the memory holds the entries beneath it.
   smx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_less1[ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_addr (count_less2[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   smx_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opnd_a (tos_ff),
      .opnd_b (ram_rd_data),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      tos_in        = tos_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      status_in     = status_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = op_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DONE;
               if (!running_ff) begin
                  status_in = ST_IGNORED;
               end else begin
                  unique case (kind) inside
                     KIND_PUSH_LO, KIND_PUSH_HI: begin
                        if (count_ff >= COUNT_W'(STACK_DEPTH)) begin
                           status_in = ST_OVERFLOW;
                        end else begin
                           ram_wr_en = (count_ff != '0);
                           tos_in    = {{KIND_W{1'b0}}, prim};
                           count_in  = count_ff + COUNT_W'(1);
                           status_in = ST_OK;
                        end
                     end
                     default: begin
                        if (prim == PRIM_HALT) begin
                           running_in = 1'b0;
                           status_in  = ST_HALT;
                        end else if (prim > PRIM_DIV) begin
                           status_in = ST_UNKNOWN;
                        end else if (count_ff < COUNT_W'(2)) begin
                           status_in = ST_UNDERFLOW;
                        end else begin
                           state_in = S_OPER;
                           unique case (prim)
                              PRIM_ADD: op_in = ALU_ADD;
                              PRIM_SUB: op_in = ALU_SUB;
                              PRIM_MUL: op_in = ALU_MUL;
                              default:  op_in = ALU_DIV;
                           endcase
                        end
                     end
                  endcase
               end
            end
         end
         S_OPER: begin
            // The entry below the top has arrived from the memory.
            if (op_ff == ALU_DIV && ram_rd_data == '0) begin
               status_in = ST_DIVZERO;
               state_in  = S_DONE;
            end else begin
               alu_ctl.start = 1'b1;
               state_in      = S_ALU;
            end
         end
         S_ALU: begin
            if (alu_done) begin
               tos_in    = alu_result;
               count_in  = count_less1;
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (count_ff == '0) ? '0 : tos_ff;
               rsp_depth_in  = DEPTH_OUT_W'(count_ff);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         running_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff        <= tos_in;
      status_ff     <= status_in;
      op_ff         <= op_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_of_stack = rsp_top_ff;
   assign rsp_stack_depth  = rsp_depth_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== bench/tb_stack_machine_executor.sv =====
`timescale 1ns / 1ps

module tb_stack_machine_executor;
   import smx_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [DATA_W-1:0]      top;
      logic [DEPTH_OUT_W-1:0] depth;
      logic [STATUS_W-1:0]    status;
   } machine_result_type;

   // Tracks the stack contents and holds the results still owed by the block.
   class stack_tracker;
      logic [DATA_W-1:0]  entries [STACK_DEPTH];
      logic [COUNT_W-1:0] depth;
      bit                 running;
      machine_result_type expected_q [$];
      int                 errors;

      function new();
         depth   = '0;
         running = 1'b1;
         errors  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_instruction(input logic [DATA_W-1:0] word);
         logic [KIND_W-1:0]   kind;
         logic [PRIM_W-1:0]   arg;
         logic [STATUS_W-1:0] st;
         logic [DATA_W-1:0]   a, b, r, mag_a, mag_b, quot;
         machine_result_type  want;
         kind = word[DATA_W-1:PRIM_W];
         arg  = word[PRIM_W-1:0];
         r    = '0;
         if (!running) begin
            st = ST_IGNORED;
         end else if (kind == KIND_PUSH_LO || kind == KIND_PUSH_HI) begin
            if (depth >= STACK_DEPTH) begin
               st = ST_OVERFLOW;
            end else begin
               entries[depth] = {{KIND_W{1'b0}}, arg};
               depth = depth + 1'b1;
               st = ST_OK;
            end
         end else if (arg == PRIM_HALT) begin
            running = 1'b0;
            st = ST_HALT;
         end else if (arg > PRIM_DIV) begin
            st = ST_UNKNOWN;
         end else if (depth < 2) begin
            st = ST_UNDERFLOW;
         end else begin
            a  = entries[depth - 1'b1];
            b  = entries[depth - 2'd2];
            st = ST_OK;
            case (arg)
               PRIM_ADD: r = a + b;
               PRIM_SUB: r = a - b;
               PRIM_MUL: r = a * b;
               default: begin
                  if (b == '0) begin
                     st = ST_DIVZERO;
                  end else begin
                     // Work on magnitudes so that the quotient truncates towards zero.
                     mag_a = a[DATA_W-1] ? -a : a;
                     mag_b = b[DATA_W-1] ? -b : b;
                     quot  = mag_a / mag_b;
                     r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
                  end
               end
            endcase
            if (st == ST_OK) begin
               entries[depth - 2'd2] = r;
               depth = depth - 1'b1;
            end
         end
         want.top    = (depth > 0) ? entries[depth - 1'b1] : '0;
         want.depth  = DEPTH_OUT_W'(depth);
         want.status = st;
         expected_q.push_back(want);
      endfunction

      function void check_result(input logic [DATA_W-1:0] top,
                                 input logic [DEPTH_OUT_W-1:0] depth_seen,
                                 input logic [STATUS_W-1:0] status);
         machine_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, top %h depth %0d status %0d",
                     $time, top, depth_seen, status);
            return;
         end
         want = expected_q.pop_front();
         if (top !== want.top) begin
            errors++;
            $display("%0t: top of stack mismatch, expected %h, actual %h",
                     $time, want.top, top);
         end
         if (depth_seen !== want.depth) begin
            errors++;
            $display("%0t: stack depth mismatch, expected %0d, actual %0d",
                     $time, want.depth, depth_seen);
         end
         if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [DATA_W-1:0]          req_instruction = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_top_of_stack;
   logic [DEPTH_OUT_W-1:0]     rsp_stack_depth;
   logic [STATUS_W-1:0]        rsp_status;

   bit           quiet = 1'b0;
   int           idle_cycles = 0;
   stack_tracker machine_model = new();

   stack_machine_executor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_top_of_stack (rsp_top_of_stack),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_status       (rsp_status)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 23);
   end

   // Result checking, plus a watchdog on cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            machine_model.check_result(rsp_top_of_stack, rsp_stack_depth, rsp_status);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("stack_machine_executor verification failed");
               $finish;
            end
         end
      end
   end

   task automatic send_instruction(input logic [DATA_W-1:0] word);
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_instruction <= word;
      do @(posedge clock); while (req_stall);
      machine_model.note_instruction(word);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (machine_model.pending() != 0);
   endtask

   // push_pct sets the share of pushes; most of the rest are arithmetic primitives.
   function automatic logic [DATA_W-1:0] next_instruction(input int push_pct);
      int                roll;
      logic [KIND_W-1:0] kind;
      logic [PRIM_W-1:0] arg;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         kind = $urandom_range(1) ? KIND_PUSH_HI : KIND_PUSH_LO;
         case ($urandom_range(3))
            0: arg = PRIM_W'($urandom_range(15));
            1: arg = PRIM_W'($urandom_range(255));
            2: arg = PRIM_W'($urandom);
            default: arg = $urandom_range(1) ? '1 : '0;
         endcase
      end else if (roll < 96) begin
         kind = $urandom_range(1) ? KIND_PRIM_HI : KIND_PRIM_LO;
         arg  = PRIM_W'($urandom_range(PRIM_DIV, PRIM_ADD));
      end else begin
         kind = $urandom_range(1) ? KIND_PRIM_HI : KIND_PRIM_LO;
         arg  = $urandom_range(1) ? PRIM_W'($urandom_range(12, 5))
                                  : (PRIM_W'($urandom) | PRIM_W'(8));
      end
      return {kind, arg};
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_instruction({KIND_PRIM_LO, PRIM_ADD});
      send_instruction({KIND_PUSH_LO, 30'h3fffffff});
      send_instruction({KIND_PRIM_HI, PRIM_SUB});
      send_instruction({KIND_PUSH_HI, 30'h3fffffff});
      send_instruction({KIND_PRIM_LO, PRIM_ADD});
      send_instruction({KIND_PUSH_HI, 30'h3fffffff});
      send_instruction({KIND_PRIM_HI, PRIM_MUL});
      send_instruction({KIND_PRIM_LO, 30'd5});
      send_instruction({KIND_PRIM_HI, 30'h3fffffff});
      send_instruction({KIND_PUSH_LO, 30'd0});
      send_instruction({KIND_PRIM_HI, PRIM_DIV});
      send_instruction({KIND_PUSH_HI, 30'd7});
      send_instruction({KIND_PRIM_LO, PRIM_DIV});
      send_instruction({KIND_PRIM_HI, PRIM_SUB});
      send_instruction({KIND_PUSH_LO, 30'd1});
      send_instruction({KIND_PUSH_LO, 30'd0});
      send_instruction({KIND_PRIM_LO, PRIM_SUB});
      send_instruction({KIND_PUSH_HI, 30'd2});
      send_instruction({KIND_PUSH_LO, 30'h20000000});
      send_instruction({KIND_PRIM_HI, PRIM_MUL});
      send_instruction({KIND_PUSH_LO, 30'd2});
      send_instruction({KIND_PRIM_LO, PRIM_MUL});
      // The most negative value divided by minus one, then a negative quotient.
      send_instruction({KIND_PRIM_HI, PRIM_DIV});
      send_instruction({KIND_PRIM_LO, PRIM_DIV});

      wait_for_results();

      quiet <= 1'b1;
      repeat (150) send_instruction(next_instruction(50));
      quiet <= 1'b0;
      repeat (450) send_instruction(next_instruction(50));

      // Fill the stack to the brim, push past it, then work it back down.
      while (machine_model.depth < STACK_DEPTH) send_instruction(next_instruction(88));
      repeat (6) send_instruction(next_instruction(100));
      while (machine_model.depth > 1) send_instruction(next_instruction(8));
      repeat (4) send_instruction(next_instruction(0));

      wait_for_results();

      // Once halted, only a reset would restart the machine, so this comes last.
      send_instruction({KIND_PRIM_LO, PRIM_HALT});
      repeat (6) send_instruction(next_instruction(50));
      send_instruction({KIND_PRIM_HI, PRIM_HALT});
      send_instruction({KIND_PUSH_HI, 30'h3fffffff});

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (machine_model.errors == 0 && machine_model.pending() == 0) begin
         $display("stack_machine_executor verification clean");
      end else begin
         $display("stack_machine_executor verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/smx_pkg.sv
hdl/smx_ram.sv
hdl/smx_alu.sv
hdl/stack_machine_executor.sv
bench/tb_stack_machine_executor.sv
